FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the symbol tracker checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define FUST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when cond holds, conseq holds in the next cycle
`define FUST_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: hw/rtl/fust_pkg.sv
// ---------------------------------------------------------------------------
// fust_pkg
// shared types and constants for the first unique symbol tracker
// ---------------------------------------------------------------------------
package fust_pkg;

  // width of the symbol field on the ports
  localparam int SYM_W = 5;

  // default alphabet size, letters a through z
  localparam int DEF_ALPHABET_SIZE = 26;

  // contents of one queue cell as seen by its neighbors
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } link_t;

endpackage

FILE: hw/rtl/fust_cell.sv
// ---------------------------------------------------------------------------
// fust_cell
// one slot of the compacting queue of symbols seen exactly once
// ---------------------------------------------------------------------------
module fust_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,       // beat accepted this cycle
  input  logic                     restart,    // clear queue before this beat
  input  logic [fust_pkg::SYM_W-1:0] in_sym,
  input  logic                     append,     // symbol is new, goes to tail
  input  logic                     prev_valid, // left neighbor occupied
  input  fust_pkg::link_t          right,      // right neighbor contents
  input  logic                     shift_in,   // removal left of here
  output logic                     shift_out,
  output fust_pkg::link_t          cur,
  output fust_pkg::link_t          nxt
);

  logic                       valid_r;
  logic [fust_pkg::SYM_W-1:0] sym_r;
  logic                       match;

  assign cur.valid = valid_r & ~restart;
  assign cur.sym   = sym_r;

  // symbol repeats: drop it from the queue
  assign match     = cur.valid && (sym_r == in_sym);
  assign shift_out = shift_in | match;

  always_comb begin
    nxt = cur;
    if (shift_out) begin
      nxt = right;
    end else if (append && !cur.valid && prev_valid) begin
      nxt.valid = 1'b1;
      nxt.sym   = in_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sym_r <= nxt.sym;
    end
  end

endmodule

FILE: hw/rtl/first_unique_symbol_tracker_top.sv
// ---------------------------------------------------------------------------
// first_unique_symbol_tracker_top
// reports the earliest-seen symbol that has occurred exactly once
// ---------------------------------------------------------------------------
// usage:
//   in channel:  one symbol per beat, in_tdata[4:0] = letter index (0 = a),
//                in_tuser = restart, which clears all history before the
//                symbol of the same beat is taken
//   out channel: one result beat per input beat, out_tdata[4:0] = symbol,
//                out_tuser = found; the symbol reads 0 when nothing is found
//   symbols at or above ALPHABET_SIZE change no history but still produce
//   a result beat with the current answer
// latency and throughput:
//   the result of a beat is registered and appears in the cycle after it is accepted;
//   one beat is taken per cycle as long as the output register is empty or being
//   drained that same cycle; a removal ripples combinationally through the cell row
// reset: all cells empty, all symbols unseen, no result pending
// stall: while a result waits on out_tready low, in_tready drops and the
//   held result stays stable
// ---------------------------------------------------------------------------
module first_unique_symbol_tracker_top #(
  parameter int ALPHABET_SIZE = fust_pkg::DEF_ALPHABET_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] symbol, [7:5] zero fill
  input  logic       in_tuser,   // [0] restart
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] unique_symbol, [7:5] zero fill
  output logic       out_tuser   // [0] found
);

  localparam int SW = fust_pkg::SYM_W;

  logic                     step;
  logic                     restart;
  logic [SW-1:0]            in_sym;
  logic                     in_range;
  logic                     seen_hit;
  logic                     append;

  // symbols seen since the last restart, once or more
  logic [ALPHABET_SIZE-1:0] seen_r;
  logic [ALPHABET_SIZE-1:0] seen_nxt;
  logic [ALPHABET_SIZE-1:0] seen_eff;
  logic [ALPHABET_SIZE-1:0] sym_onehot;

  // queue of once-seen symbols, oldest in cell 0
  fust_pkg::link_t          cur_lnk [ALPHABET_SIZE];
  fust_pkg::link_t          cell_nxt [ALPHABET_SIZE];
  fust_pkg::link_t          head_nxt;
  logic [ALPHABET_SIZE:0]   shift_chain;

  // output register
  logic                     out_valid_r;
  logic                     out_found_r;
  logic [SW-1:0]            out_sym_r;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;
  assign restart   = step && in_tuser;
  assign in_sym    = in_tdata[SW-1:0];
  assign in_range  = 32'(in_sym) < 32'(ALPHABET_SIZE);

  // seen lookup, one compare per alphabet entry
  generate
    for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_seen
      assign sym_onehot[i] = in_range && (32'(in_sym) == 32'(i));
    end
  endgenerate

  assign seen_eff = restart ? '0 : seen_r;
  assign seen_hit = |(seen_eff & sym_onehot);
  assign seen_nxt = seen_eff | sym_onehot;
  // first occurrence joins the tail; a second one leaves the queue via match
  assign append   = in_range && !seen_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (step) begin
      seen_r <= seen_nxt;
    end
  end

  // row of cells; a removal shifts everything to its right one place left
  assign shift_chain[0] = 1'b0;

  generate
    for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
      logic            prev_v;
      fust_pkg::link_t right_lnk;

      if (k == 0) begin : g_first
        assign prev_v = 1'b1;
      end else begin : g_rest
        assign prev_v = cur_lnk[k-1].valid;
      end

      if (k == ALPHABET_SIZE - 1) begin : g_last
        assign right_lnk = '0;
      end else begin : g_inner
        assign right_lnk = cur_lnk[k+1];
      end

      fust_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .restart    (restart),
        .in_sym     (in_sym),
        .append     (append),
        .prev_valid (prev_v),
        .right      (right_lnk),
        .shift_in   (shift_chain[k]),
        .shift_out  (shift_chain[k+1]),
        .cur        (cur_lnk[k]),
        .nxt        (cell_nxt[k])
      );
    end
  endgenerate

  // the answer is whatever lands in the head cell
  assign head_nxt = cell_nxt[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_found_r <= head_nxt.valid;
      out_sym_r   <= head_nxt.valid ? head_nxt.sym : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {(8 - SW)'(0), out_sym_r};

endmodule

FILE: hw/rtl/fust_checker.sv
// ---------------------------------------------------------------------------
// fust_checker
// port-level checks for the first unique symbol tracker
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fust_checker #(
  parameter int ALPHABET_SIZE = fust_pkg::DEF_ALPHABET_SIZE
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  logic       in_acc;
  logic       sym_ok;
  logic       rst_ok;
  logic       rst_bad;
  logic       hit_ok;
  logic       miss_ok;
  logic       stall;
  logic [8:0] out_word;
  logic [4:0] in_sym_r;

  assign in_acc   = in_tvalid && in_tready;
  assign sym_ok   = 32'(in_tdata[4:0]) < 32'(ALPHABET_SIZE);
  assign rst_ok   = in_acc && in_tuser && sym_ok;
  assign rst_bad  = in_acc && in_tuser && !sym_ok;
  assign hit_ok   = out_tuser && (out_tdata[4:0] == in_sym_r);
  assign miss_ok  = !out_tuser && (out_tdata == 8'd0);
  assign stall    = out_tvalid && !out_tready;
  assign out_word = {out_tuser, out_tdata};

  // symbol offered in the previous cycle
  always_ff @(posedge clk) begin
    in_sym_r <= in_tdata[4:0];
  end

  // every accepted beat yields a result on the next cycle
  `FUST_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_tvalid, "missing result beat")

  // restart with a valid symbol: that symbol is the answer
  `FUST_ASSERT_NEXT(a_restart_hit, clk, rst_n, rst_ok, hit_ok, "restart symbol not reported")

  // restart with an out-of-range symbol: nothing is found
  `FUST_ASSERT_NEXT(a_restart_miss, clk, rst_n, rst_bad, miss_ok, "stale answer after restart")

  // a stalled result holds
  `FUST_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_tvalid && $stable(out_word), "stall not held")

endmodule

bind first_unique_symbol_tracker_top fust_checker #(
  .ALPHABET_SIZE(ALPHABET_SIZE)
) u_fust_checker (.*);
